>>> src/rhms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhms_pkg
// Shared constants and types for the ROM header map scoring block.
// ----------------------------------------------------------------------------
package rhms_pkg;

    // header window layout
    localparam logic [6:0] OFS_CODE_END   = 7'h06;
    localparam logic [6:0] OFS_TITLE      = 7'h10;
    localparam logic [6:0] OFS_TITLE_END  = 7'h24;
    localparam logic [6:0] OFS_MAP_MODE   = 7'h25;
    localparam logic [6:0] OFS_SIZE       = 7'h27;
    localparam logic [6:0] OFS_MAKER      = 7'h2A;
    localparam logic [6:0] OFS_CSUM_FIRST = 7'h2C;
    localparam logic [6:0] OFS_CSUM_LAST  = 7'h2F;
    localparam logic [6:0] OFS_RESET_HI   = 7'h4D;
    localparam logic [6:0] WINDOW_LEN     = 7'd80;

    localparam logic [7:0]  MAKER_ID      = 8'h33;
    localparam logic [7:0]  SIZE_LIMIT    = 8'd13;
    localparam logic [7:0]  PRINT_LO      = 8'd32;
    localparam logic [7:0]  PRINT_HI      = 8'd126;
    localparam logic [3:0]  MAP_NIB_LIMIT = 4'd4;
    localparam logic [16:0] CSUM_MATCH    = 17'h0FFFF;

    // single test flag bits
    localparam int FLAG_MAKER = 0;
    localparam int FLAG_MAP   = 1;
    localparam int FLAG_RESET = 2;
    localparam int FLAG_SIZE  = 3;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef logic signed [3:0] t_score;

    // byte update sent to one window tracker
    typedef struct packed {
        logic       take;
        logic       flush;
        logic [6:0] ofs;
        logic [7:0] value;
    } t_byte_upd;

    function automatic logic is_printable(input logic [7:0] v);
        is_printable = (v >= PRINT_LO) && (v <= PRINT_HI);
    endfunction

endpackage

>>> src/rhms_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhms_window
// Header state of one map window: checksum field, test flags, text flags,
// and the window score taken from the state after the current byte.
// ----------------------------------------------------------------------------
module rhms_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rhms_pkg::t_byte_upd i_upd,
    output rhms_pkg::t_score   o_score
);

    logic [7:0] r_csum [4];
    logic [7:0] n_csum [4];
    logic [3:0] r_flags, n_flags;
    logic [1:0] r_print, n_print;
    logic [6:0] w_csum_diff;
    logic [16:0] w_csum_total;
    logic signed [4:0] w_sum;

    assign w_csum_diff = i_upd.ofs - rhms_pkg::OFS_CSUM_FIRST;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_csum[i] = r_csum[i];
        end
        n_flags = r_flags;
        n_print = r_print;
        if (i_upd.take && (i_upd.ofs < rhms_pkg::WINDOW_LEN)) begin
            if (!rhms_pkg::is_printable(i_upd.value)) begin
                if (i_upd.ofs < rhms_pkg::OFS_CODE_END) begin
                    n_print[0] = 1'b0;
                end
                if ((i_upd.ofs >= rhms_pkg::OFS_TITLE) &&
                    (i_upd.ofs < rhms_pkg::OFS_TITLE_END)) begin
                    n_print[1] = 1'b0;
                end
            end
            if ((i_upd.ofs >= rhms_pkg::OFS_CSUM_FIRST) &&
                (i_upd.ofs <= rhms_pkg::OFS_CSUM_LAST)) begin
                n_csum[w_csum_diff[1:0]] = i_upd.value;
            end
            if (i_upd.ofs == rhms_pkg::OFS_MAKER) begin
                n_flags[rhms_pkg::FLAG_MAKER] = (i_upd.value == rhms_pkg::MAKER_ID);
            end
            if (i_upd.ofs == rhms_pkg::OFS_MAP_MODE) begin
                n_flags[rhms_pkg::FLAG_MAP] = (i_upd.value[3:0] < rhms_pkg::MAP_NIB_LIMIT);
            end
            if (i_upd.ofs == rhms_pkg::OFS_RESET_HI) begin
                n_flags[rhms_pkg::FLAG_RESET] = ~i_upd.value[7];
            end
            if (i_upd.ofs == rhms_pkg::OFS_SIZE) begin
                n_flags[rhms_pkg::FLAG_SIZE] = (i_upd.value >= rhms_pkg::SIZE_LIMIT);
            end
        end
    end

    // complement + checksum, each little endian
    assign w_csum_total = {1'b0, n_csum[1], n_csum[0]} + {1'b0, n_csum[3], n_csum[2]};

    always_comb begin
        w_sum = 5'sd0;
        if (w_csum_total == rhms_pkg::CSUM_MATCH) w_sum = w_sum + 5'sd2;
        if (n_flags[rhms_pkg::FLAG_MAKER])        w_sum = w_sum + 5'sd2;
        if (n_flags[rhms_pkg::FLAG_MAP])          w_sum = w_sum + 5'sd2;
        if (n_flags[rhms_pkg::FLAG_RESET])        w_sum = w_sum - 5'sd4;
        if (n_flags[rhms_pkg::FLAG_SIZE])         w_sum = w_sum - 5'sd1;
        if (!n_print[0])                          w_sum = w_sum - 5'sd1;
        if (!n_print[1])                          w_sum = w_sum - 5'sd1;
    end

    assign o_score = w_sum[3:0];

    // drop all state after the final byte so the next header pair starts fresh
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_upd.flush) begin
            for (int i = 0; i < 4; i++) begin
                r_csum[i] <= '0;
            end
            r_flags <= '0;
            r_print <= '1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                r_csum[i] <= n_csum[i];
            end
            r_flags <= n_flags;
            r_print <= n_print;
        end
    end

endmodule

>>> src/rom_header_map_score_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_header_map_score_core
// Scores a low-map and a high-map cartridge header window and picks the map.
// ----------------------------------------------------------------------------
// Takes one header byte per cycle unless a final byte stalls. Each item
// goes into an input register and updates its window's state as it leaves
// it; an item with tlast loads the result register with both scores and the
// verdict, so a result follows its final byte through the input and result
// registers. The only stall is a final byte meeting a result that the sink
// has not yet taken; both windows reset their state after every final byte.
module rom_header_map_score_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [6:0] byte_offset, [14:7] byte_value, [15] zero
    input  logic [rhms_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] candidate
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] low_map_score, [7:4] high_map_score, [8] is_high_map, [15:9] zero
    output logic [rhms_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    logic       r_in_valid;
    logic       r_in_cand;
    logic       r_in_last;
    logic [6:0] r_in_ofs;
    logic [7:0] r_in_val;

    logic       r_out_valid;
    rhms_pkg::t_score r_out_lo, r_out_hi;
    logic       r_out_high;

    logic       w_advance;
    rhms_pkg::t_byte_upd w_upd_lo, w_upd_hi;
    rhms_pkg::t_score    w_score_lo, w_score_hi;

    // a final byte waits only while the result register is still full and not being taken
    assign w_advance     = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cand <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
            r_in_ofs  <= s_axis_tdata[6:0];
            r_in_val  <= s_axis_tdata[14:7];
        end
    end

    always_comb begin
        w_upd_lo.take  = w_advance && !r_in_cand;
        w_upd_lo.flush = w_advance && r_in_last;
        w_upd_lo.ofs   = r_in_ofs;
        w_upd_lo.value = r_in_val;
        w_upd_hi.take  = w_advance && r_in_cand;
        w_upd_hi.flush = w_advance && r_in_last;
        w_upd_hi.ofs   = r_in_ofs;
        w_upd_hi.value = r_in_val;
    end

    rhms_window u_win_lo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd_lo),
        .o_score (w_score_lo)
    );

    rhms_window u_win_hi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd_hi),
        .o_score (w_score_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_last) begin
            r_out_lo   <= w_score_lo;
            r_out_hi   <= w_score_hi;
            r_out_high <= (w_score_hi > w_score_lo);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_high, r_out_hi, r_out_lo};

    // a result only follows a final byte leaving the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result appeared without a final byte");

    // verdict agrees with the two scores it carries
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_high == (r_out_hi > r_out_lo)))
        else $error("map verdict does not match scores");

    // a held final byte must not be overwritten
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_ofs)
                                        && $stable(r_in_last) && $stable(r_in_cand)))
        else $error("stalled input stage lost its item");

    // a pending result is never replaced before the sink takes it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !(w_advance && r_in_last))
        else $error("result register overwritten");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ROM header map scoring core.
// ----------------------------------------------------------------------------
// Header bytes for the low-map and high-map windows stream in on the slave
// side with random gaps. A scoring model inside the bench tracks both windows
// and queues the verdict that each final byte should produce. The master side
// stalls at random, and every verdict is checked field by field in order.
module tb;

    localparam int RANDOM_ITEMS = 1550;
    localparam int MAX_PAUSE    = 12;
    localparam int STALL_LIMIT  = 400;

    typedef struct {
        bit       cand;
        bit [6:0] ofs;
        bit [7:0] val;
        bit       last;
    } t_hdr_byte;

    typedef struct {
        rhms_pkg::t_score low;
        rhms_pkg::t_score high;
        bit               high_wins;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [6:0] byte_offset, [14:7] byte_value, [15] zero
    logic [rhms_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // [0] candidate
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] low_map_score, [7:4] high_map_score, [8] is_high_map, [15:9] zero
    logic [rhms_pkg::M_TDATA_W-1:0] m_axis_tdata;

    t_hdr_byte pending_bytes[$];
    t_verdict  verdicts_due[$];
    t_hdr_byte byte_on_bus;

    // per-window header state
    bit [7:0] win_csum [2][4];
    bit [3:0] win_flags [2];
    bit [1:0] win_print [2];

    int  mismatches = 0;
    int  tx_wait = 0;
    int  rx_wait = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    int  idle_cycles = 0;

    rom_header_map_score_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void clear_windows();
        for (int w = 0; w < 2; w++) begin
            for (int k = 0; k < 4; k++) win_csum[w][k] = 8'h00;
            win_flags[w] = 4'h0;
            win_print[w] = 2'b11;
        end
    endfunction

    function automatic void absorb_byte(t_hdr_byte b);
        bit printable;
        if (b.ofs >= rhms_pkg::WINDOW_LEN) return;
        printable = (b.val >= rhms_pkg::PRINT_LO) && (b.val <= rhms_pkg::PRINT_HI);
        if (b.ofs < rhms_pkg::OFS_CODE_END && !printable) win_print[b.cand][0] = 1'b0;
        if (b.ofs >= rhms_pkg::OFS_TITLE && b.ofs < rhms_pkg::OFS_TITLE_END && !printable)
            win_print[b.cand][1] = 1'b0;
        if (b.ofs >= rhms_pkg::OFS_CSUM_FIRST && b.ofs <= rhms_pkg::OFS_CSUM_LAST)
            win_csum[b.cand][2'(b.ofs - rhms_pkg::OFS_CSUM_FIRST)] = b.val;
        case (b.ofs)
            rhms_pkg::OFS_MAKER:
                win_flags[b.cand][rhms_pkg::FLAG_MAKER] = (b.val == rhms_pkg::MAKER_ID);
            rhms_pkg::OFS_MAP_MODE:
                win_flags[b.cand][rhms_pkg::FLAG_MAP] =
                    (b.val[3:0] < rhms_pkg::MAP_NIB_LIMIT);
            rhms_pkg::OFS_RESET_HI:
                win_flags[b.cand][rhms_pkg::FLAG_RESET] = !b.val[7];
            rhms_pkg::OFS_SIZE:
                win_flags[b.cand][rhms_pkg::FLAG_SIZE] = (b.val >= rhms_pkg::SIZE_LIMIT);
            default: ;
        endcase
    endfunction

    function automatic rhms_pkg::t_score window_score(int w);
        int        s;
        bit [16:0] total;
        s = 0;
        total = {win_csum[w][1], win_csum[w][0]} + {win_csum[w][3], win_csum[w][2]};
        if (total == rhms_pkg::CSUM_MATCH) s += 2;
        if (win_flags[w][rhms_pkg::FLAG_MAKER]) s += 2;
        if (win_flags[w][rhms_pkg::FLAG_MAP]) s += 2;
        if (win_flags[w][rhms_pkg::FLAG_RESET]) s -= 4;
        if (win_flags[w][rhms_pkg::FLAG_SIZE]) s -= 1;
        if (!win_print[w][0]) s -= 1;
        if (!win_print[w][1]) s -= 1;
        return rhms_pkg::t_score'(s);
    endfunction

    function automatic void score_byte(t_hdr_byte b);
        t_verdict v;
        absorb_byte(b);
        if (!b.last) return;
        v.low = window_score(0);
        v.high = window_score(1);
        v.high_wins = (v.high > v.low);
        verdicts_due.push_back(v);
        clear_windows();
    endfunction

    function automatic void queue_byte(bit cand, bit [6:0] ofs, bit [7:0] val, bit last);
        t_hdr_byte b;
        b.cand = cand;
        b.ofs = ofs;
        b.val = val;
        b.last = last;
        pending_bytes.push_back(b);
    endfunction

    // lean toward the offsets that feed the score
    function automatic bit [6:0] pick_offset();
        case ($urandom_range(0, 15))
            0, 1:    return 7'($urandom_range(0, 5));
            2, 3:    return 7'($urandom_range(rhms_pkg::OFS_TITLE,
                                              rhms_pkg::OFS_TITLE_END - 1));
            4:       return rhms_pkg::OFS_MAP_MODE;
            5:       return rhms_pkg::OFS_SIZE;
            6:       return rhms_pkg::OFS_MAKER;
            7, 8:    return 7'($urandom_range(rhms_pkg::OFS_CSUM_FIRST,
                                              rhms_pkg::OFS_CSUM_LAST));
            9:       return rhms_pkg::OFS_RESET_HI;
            10:      return 7'($urandom_range(rhms_pkg::WINDOW_LEN, 127));
            default: return 7'($urandom_range(0, rhms_pkg::WINDOW_LEN - 1));
        endcase
    endfunction

    function automatic bit [7:0] pick_value(bit [6:0] ofs);
        bit text;
        text = (ofs < rhms_pkg::OFS_CODE_END) ||
               (ofs >= rhms_pkg::OFS_TITLE && ofs < rhms_pkg::OFS_TITLE_END);
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        if (text) begin
            case ($urandom_range(0, 7))
                0:       return rhms_pkg::PRINT_LO - 8'd1;
                1:       return rhms_pkg::PRINT_LO;
                2:       return rhms_pkg::PRINT_HI;
                3:       return rhms_pkg::PRINT_HI + 8'd1;
                default: return 8'($urandom_range(rhms_pkg::PRINT_LO, rhms_pkg::PRINT_HI));
            endcase
        end
        case (ofs)
            rhms_pkg::OFS_MAKER:
                return ($urandom_range(0, 1) == 1) ? rhms_pkg::MAKER_ID : 8'($urandom);
            rhms_pkg::OFS_SIZE:
                return 8'($urandom_range(0, 20));
            default:
                return 8'($urandom);
        endcase
    endfunction

    // slave side: present queued bytes with random gaps between items
    always @(posedge i_clk) begin : drive_bytes
        int n;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                score_byte(byte_on_bus);
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                n = tx_burst ? 0 : $urandom_range(0, MAX_PAUSE);
            end else begin
                n = tx_wait;
            end
            if (n == 0 && pending_bytes.size() != 0) begin
                byte_on_bus = pending_bytes.pop_front();
                s_axis_tdata <= {1'b0, byte_on_bus.val, byte_on_bus.ofs};
                s_axis_tuser <= byte_on_bus.cand;
                s_axis_tlast <= byte_on_bus.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
                if (n > 0) n--;
            end
            tx_wait <= n;
        end
    end

    // master side: stall at random, check each verdict against the oldest one due
    always @(posedge i_clk) begin : check_verdicts
        int       n;
        t_verdict v;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected verdict: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                v = verdicts_due.pop_front();
                if ($signed(m_axis_tdata[3:0]) !== v.low) begin
                    $error("low_map_score: expected %0d, actual %0d",
                           v.low, $signed(m_axis_tdata[3:0]));
                    mismatches++;
                end
                if ($signed(m_axis_tdata[7:4]) !== v.high) begin
                    $error("high_map_score: expected %0d, actual %0d",
                           v.high, $signed(m_axis_tdata[7:4]));
                    mismatches++;
                end
                if (m_axis_tdata[8] !== v.high_wins) begin
                    $error("is_high_map: expected %0d, actual %0d",
                           v.high_wins, m_axis_tdata[8]);
                    mismatches++;
                end
            end
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, MAX_PAUSE);
            rx_wait <= n;
            m_axis_tready <= (n == 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            m_axis_tready <= (rx_wait == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int       count;
        int       full_frames;
        int       n;
        bit       cand;
        bit [6:0] ofs;
        bit [15:0] comp;
        bit [15:0] sum;

        clear_windows();

        // high window at its best, low window at its worst
        queue_byte(1, rhms_pkg::OFS_CSUM_FIRST, 8'h12, 0);
        queue_byte(1, rhms_pkg::OFS_CSUM_FIRST + 7'd1, 8'h34, 0);
        queue_byte(1, rhms_pkg::OFS_CSUM_FIRST + 7'd2, 8'hED, 0);
        queue_byte(1, rhms_pkg::OFS_CSUM_LAST, 8'hCB, 0);
        queue_byte(1, rhms_pkg::OFS_MAKER, rhms_pkg::MAKER_ID, 0);
        queue_byte(1, rhms_pkg::OFS_MAP_MODE, 8'h20, 0);
        queue_byte(1, rhms_pkg::OFS_RESET_HI, 8'h80, 0);
        queue_byte(1, rhms_pkg::OFS_SIZE, rhms_pkg::SIZE_LIMIT - 8'd1, 0);
        queue_byte(0, rhms_pkg::OFS_RESET_HI, 8'h00, 0);
        queue_byte(0, rhms_pkg::OFS_SIZE, rhms_pkg::SIZE_LIMIT, 0);
        queue_byte(0, 7'd0, 8'h1F, 0);
        queue_byte(0, rhms_pkg::OFS_TITLE, 8'h7F, 0);
        queue_byte(0, rhms_pkg::WINDOW_LEN - 7'd1, 8'hFF, 0);
        queue_byte(0, 7'd127, 8'hFF, 1);
        // lone final byte: nothing else sent, a tie
        queue_byte(0, 7'd0, rhms_pkg::PRINT_LO, 1);
        // bytes sent twice, small size, text edges
        queue_byte(0, rhms_pkg::OFS_MAKER, rhms_pkg::MAKER_ID, 0);
        queue_byte(0, rhms_pkg::OFS_MAKER, 8'h34, 0);
        queue_byte(1, rhms_pkg::OFS_MAKER, rhms_pkg::MAKER_ID, 0);
        queue_byte(0, rhms_pkg::OFS_MAP_MODE, 8'h13, 0);
        queue_byte(1, rhms_pkg::OFS_SIZE, 8'h06, 0);
        queue_byte(0, 7'd0, 8'h7F, 0);
        queue_byte(0, 7'd0, 8'h41, 0);
        queue_byte(1, rhms_pkg::OFS_TITLE_END - 7'd1, rhms_pkg::PRINT_HI, 0);
        queue_byte(1, rhms_pkg::OFS_CODE_END - 7'd1, rhms_pkg::PRINT_LO, 0);
        queue_byte(1, rhms_pkg::OFS_RESET_HI, 8'h7F, 1);

        count = 0;
        full_frames = 0;
        while (count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0: begin
                    // complete pair of windows
                    if (full_frames < 3) begin
                        full_frames++;
                        cand = 1'($urandom_range(0, 1));
                        for (int w = 0; w < 2; w++) begin
                            for (int k = 0; k < rhms_pkg::WINDOW_LEN; k++) begin
                                queue_byte(cand ^ w[0], 7'(k), pick_value(7'(k)),
                                           w == 1 && k == rhms_pkg::WINDOW_LEN - 1);
                            end
                        end
                        count += 2 * rhms_pkg::WINDOW_LEN;
                    end
                end
                1, 2: begin
                    // noise: any offset, stray final bytes
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) begin
                        ofs = 7'($urandom_range(0, 127));
                        queue_byte(1'($urandom_range(0, 1)), ofs, 8'($urandom),
                                   $urandom_range(0, 7) == 0);
                        count++;
                    end
                end
                default: begin
                    n = $urandom_range(1, 30);
                    for (int k = 0; k < n; k++) begin
                        ofs = pick_offset();
                        queue_byte(1'($urandom_range(0, 1)), ofs, pick_value(ofs), 0);
                        count++;
                    end
                    // checksum pair that mostly matches its complement
                    if ($urandom_range(0, 1) == 1) begin
                        cand = 1'($urandom_range(0, 1));
                        comp = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
                        sum = ~comp;
                        if ($urandom_range(0, 3) == 0) sum = sum + 16'd1;
                        queue_byte(cand, rhms_pkg::OFS_CSUM_FIRST, comp[7:0], 0);
                        queue_byte(cand, rhms_pkg::OFS_CSUM_FIRST + 7'd1, comp[15:8], 0);
                        queue_byte(cand, rhms_pkg::OFS_CSUM_FIRST + 7'd2, sum[7:0], 0);
                        queue_byte(cand, rhms_pkg::OFS_CSUM_LAST, sum[15:8], 0);
                        count += 4;
                    end
                    ofs = pick_offset();
                    queue_byte(1'($urandom_range(0, 1)), ofs, pick_value(ofs), 1);
                    count++;
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
src/rhms_pkg.sv
src/rhms_window.sv
src/rom_header_map_score_core.sv
tb/tb.sv
